/* hdl/lpsd_pkg.sv */
package lpsd_pkg;

   localparam logic [7:0] SEPARATOR  = 8'h7C;
   localparam logic [7:0] DIGIT_ZERO = 8'h30;
   localparam logic [7:0] DIGIT_NINE = 8'h39;

   localparam int MAX_LENGTH_WIDTH = 16;
   localparam logic [MAX_LENGTH_WIDTH-1:0] MAX_LENGTH_RESET = 16'hFFFF;

   typedef enum logic [1:0] {
      ERR_NONE         = 2'd0,
      ERR_NON_DIGIT    = 2'd1,
      ERR_TOO_LARGE    = 2'd2,
      ERR_EMPTY_LENGTH = 2'd3
   } error_code_type;

   typedef struct packed {
      logic [7:0]     data_byte;
      logic           last_of_string;
      logic           empty_string;
      error_code_type error_code;
   } result_type;

endpackage

/* hdl/lpsd_step.sv */
module lpsd_step #(
   parameter int LENGTH_WIDTH = 16
) (
   input  logic [7:0]                                in_byte,
   input  logic [lpsd_pkg::MAX_LENGTH_WIDTH-1:0]     max_length,
   input  logic                                      in_payload,
   input  logic [LENGTH_WIDTH:0]                     length_acc,
   input  logic                                      digits_seen,
   input  logic [LENGTH_WIDTH-1:0]                   bytes_remaining,
   output logic                                      in_payload_next,
   output logic [LENGTH_WIDTH:0]                     length_acc_next,
   output logic                                      digits_seen_next,
   output logic [LENGTH_WIDTH-1:0]                   bytes_remaining_next,
   output logic                                      has_result,
   output lpsd_pkg::result_type                      result
);

   localparam int PROD_WIDTH = LENGTH_WIDTH + 5;
   localparam int CMP_WIDTH  = LENGTH_WIDTH + 1 + lpsd_pkg::MAX_LENGTH_WIDTH;

   logic [PROD_WIDTH-1:0]   acc_wide;
   logic [PROD_WIDTH-1:0]   acc_times_ten;
   logic [CMP_WIDTH-1:0]    acc_cmp;
   logic [CMP_WIDTH-1:0]    max_cmp;
   logic [7:0]              digit_offset;
   logic [LENGTH_WIDTH-1:0] remaining_dec;
   logic                    too_large;

   always_comb begin
      acc_wide      = {4'b0, length_acc};
      digit_offset  = in_byte - lpsd_pkg::DIGIT_ZERO;
      // Multiply by ten as 8x + 2x, then add the digit value.
      acc_times_ten = (acc_wide << 3) + (acc_wide << 1)
                      + {{(PROD_WIDTH-4){1'b0}}, digit_offset[3:0]};
      acc_cmp       = {{lpsd_pkg::MAX_LENGTH_WIDTH{1'b0}}, length_acc};
      max_cmp       = {{(LENGTH_WIDTH+1){1'b0}}, max_length};
      too_large     = length_acc[LENGTH_WIDTH] || (acc_cmp > max_cmp);
      remaining_dec = bytes_remaining - {{(LENGTH_WIDTH-1){1'b0}}, 1'b1};
   end

   always_comb begin
      in_payload_next      = in_payload;
      length_acc_next      = length_acc;
      digits_seen_next     = digits_seen;
      bytes_remaining_next = bytes_remaining;
      has_result           = 1'b0;
      result.data_byte      = 8'h00;
      result.last_of_string = 1'b0;
      result.empty_string   = 1'b0;
      result.error_code     = lpsd_pkg::ERR_NONE;

      if (in_payload) begin
         bytes_remaining_next = remaining_dec;
         has_result           = 1'b1;
         result.data_byte     = in_byte;
         if (remaining_dec == '0) begin
            in_payload_next       = 1'b0;
            result.last_of_string = 1'b1;
         end
      end else if (in_byte inside {[lpsd_pkg::DIGIT_ZERO:lpsd_pkg::DIGIT_NINE]}) begin
         // The accumulator saturates at all ones instead of wrapping.
         if (acc_times_ten[PROD_WIDTH-1:LENGTH_WIDTH+1] != '0) begin
            length_acc_next = '1;
         end else begin
            length_acc_next = acc_times_ten[LENGTH_WIDTH:0];
         end
         digits_seen_next = 1'b1;
      end else begin
         // Every non-digit in the length phase ends the length field.
         length_acc_next  = '0;
         digits_seen_next = 1'b0;
         has_result       = 1'b1;
         if (in_byte != lpsd_pkg::SEPARATOR) begin
            result.error_code = lpsd_pkg::ERR_NON_DIGIT;
         end else if (!digits_seen) begin
            result.error_code = lpsd_pkg::ERR_EMPTY_LENGTH;
         end else if (too_large) begin
            result.error_code = lpsd_pkg::ERR_TOO_LARGE;
         end else if (length_acc == '0) begin
            result.empty_string = 1'b1;
         end else begin
            has_result           = 1'b0;
            in_payload_next      = 1'b1;
            bytes_remaining_next = length_acc[LENGTH_WIDTH-1:0];
         end
      end
   end

endmodule

/* hdl/length_prefixed_string_deframer.sv */
// Results are registered: a result appears on the rsp_ channel in the cycle after the byte that causes it.
// Throughput: one byte per cycle; the single result register is refilled in the cycle
// it is taken, so req_stall rises only while a waiting result is stalled.
// Reset (synchronous, active high) returns to the length phase with an empty length field,
// no pending result, and max_length set to 65535.
module length_prefixed_string_deframer #(
   parameter int LENGTH_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [7:0]                            req_in_byte,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [7:0]                            rsp_data_byte,
   output logic                                  rsp_last_of_string,
   output logic                                  rsp_empty_string,
   output logic [1:0]                            rsp_error_code,
   input  logic                                  csr_write_enable,
   input  logic [lpsd_pkg::MAX_LENGTH_WIDTH-1:0] csr_write_data
);

   logic [lpsd_pkg::MAX_LENGTH_WIDTH-1:0] max_length_ff;
   logic                                  in_payload_ff;
   logic                                  in_payload_in;
   logic [LENGTH_WIDTH:0]                 length_acc_ff;
   logic [LENGTH_WIDTH:0]                 length_acc_in;
   logic                                  digits_seen_ff;
   logic                                  digits_seen_in;
   logic [LENGTH_WIDTH-1:0]               bytes_remaining_ff;
   logic [LENGTH_WIDTH-1:0]               bytes_remaining_in;
   logic                                  rsp_valid_ff;
   logic                                  rsp_valid_in;
   lpsd_pkg::result_type                  rsp_ff;
   lpsd_pkg::result_type                  rsp_in;

   logic                                  req_accept;
   logic                                  out_free;
   logic                                  step_has_result;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !out_free;
   assign req_accept = req_valid && out_free;

   lpsd_step #(
      .LENGTH_WIDTH(LENGTH_WIDTH)
   ) u_step (
      .in_byte              (req_in_byte),
      .max_length           (max_length_ff),
      .in_payload           (in_payload_ff),
      .length_acc           (length_acc_ff),
      .digits_seen          (digits_seen_ff),
      .bytes_remaining      (bytes_remaining_ff),
      .in_payload_next      (in_payload_in),
      .length_acc_next      (length_acc_in),
      .digits_seen_next     (digits_seen_in),
      .bytes_remaining_next (bytes_remaining_in),
      .has_result           (step_has_result),
      .result               (rsp_in)
   );

   // The result valid flag updates whenever the register is free; an accepted transaction
   // without a result simply leaves it empty.
   assign rsp_valid_in = out_free ? (req_accept && step_has_result) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff      <= lpsd_pkg::MAX_LENGTH_RESET;
         in_payload_ff      <= 1'b0;
         length_acc_ff      <= '0;
         digits_seen_ff     <= 1'b0;
         bytes_remaining_ff <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            max_length_ff <= csr_write_data;
         end
         if (req_accept) begin
            in_payload_ff      <= in_payload_in;
            length_acc_ff      <= length_acc_in;
            digits_seen_ff     <= digits_seen_in;
            bytes_remaining_ff <= bytes_remaining_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && step_has_result) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data_byte      = rsp_ff.data_byte;
   assign rsp_last_of_string = rsp_ff.last_of_string;
   assign rsp_empty_string   = rsp_ff.empty_string;
   assign rsp_error_code     = rsp_ff.error_code;

endmodule
